// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of clk outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Signal that must hold on every rising edge of clk outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`endif

// ----- design/fdrt_pkg.sv -----
// ---------------------------------------------------------------------------
// fdrt_pkg
// Types and codes shared by the radix trie table and its testbench.
// ---------------------------------------------------------------------------
package fdrt_pkg;

	localparam int KEY_BITS = 32;

	localparam logic [1:0] MODE_FIND   = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_DELETE = 2'd2;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_MISS = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] key;
		logic [31:0] mask;
		logic [31:0] value;
	} fdrt_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] data_out;
	} fdrt_rsp_t;

endpackage

// ----- design/fixed_depth_radix_trie_table.sv -----
// ---------------------------------------------------------------------------
// fixed_depth_radix_trie_table
// Fixed-height multibit trie with find, insert and delete held in RAMs.
// ---------------------------------------------------------------------------
// One transaction is handled at a time; busy is high while it runs and the
// result appears for one cycle on done. Each trie level is a child slot
// read (ST_RD) and then its evaluation (ST_EVAL) through the read port of
// the single child RAM, and a find or delete miss ends the walk early.
// Every node that insert creates has its child row cleared (ST_CLR) and is
// then linked (ST_LINK), after a free-list read (ST_FLW) when it is taken
// from there. The root row is tracked by flags that reset clears, so no
// clearing pass runs after reset.
module fixed_depth_radix_trie_table
	import fdrt_pkg::*;
#(
	parameter int DIGIT_BITS = 4,
	parameter int NODE_COUNT = 256,
	parameter int VALUE_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  fdrt_req_t req,
	output logic      done,
	output fdrt_rsp_t rsp
);

	`include "assert_macros.svh"

	localparam int FANOUT = 1 << DIGIT_BITS;
	localparam int HEIGHT = KEY_BITS / DIGIT_BITS;
	localparam int NW     = $clog2(NODE_COUNT);
	localparam int LW     = $clog2(HEIGHT + 1);
	localparam int CW     = NW + DIGIT_BITS;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD, ST_EVAL, ST_FLW, ST_CLR, ST_LINK, ST_LEAF
	} state_t;

	state_t                state_q;
	logic [1:0]            mode_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [31:0]           value_q;
	logic [LW-1:0]         lvl_q;
	logic [NW-1:0]         node_q;
	logic [NW-1:0]         new_q;
	logic [DIGIT_BITS-1:0] clr_q;
	logic [NW-1:0]         free_head_q;
	logic [NW:0]           fresh_q;
	logic [FANOUT-1:0]     root_vld_q;

	logic                  c_we, c_re, l_we, l_re, f_we, f_re;
	logic [CW-1:0]         c_waddr, c_raddr;
	logic [NW-1:0]         c_wdata, c_rdata, f_rdata;
	logic [NW-1:0]         l_addr, f_waddr;
	logic [VALUE_BITS-1:0] l_rdata, l_wdata;
	logic [63:0]           val_ext, leaf_ext;
	logic [DIGIT_BITS-1:0] dig;
	logic [NW-1:0]         child;
	logic                  last_lvl;

	assign dig      = key_q[DIGIT_BITS-1:0];
	assign child    = (node_q == '0 && !root_vld_q[dig]) ? '0 : c_rdata;
	assign last_lvl = (lvl_q == LW'(HEIGHT - 1));
	assign val_ext  = {32'd0, value_q};
	assign l_wdata  = val_ext[VALUE_BITS-1:0];
	assign leaf_ext = 64'(l_rdata);
	assign busy     = (state_q != ST_IDLE);

	always_comb begin
		c_we    = 1'b0;
		c_waddr = {node_q, dig};
		c_wdata = '0;
		c_re    = 1'b0;
		c_raddr = {node_q, dig};
		l_we    = 1'b0;
		l_re    = 1'b0;
		l_addr  = child;
		f_we    = 1'b0;
		f_waddr = child;
		f_re    = 1'b0;
		unique case (state_q)
			ST_RD: begin
				c_re = 1'b1;
			end
			ST_EVAL: begin
				case (mode_q)
					MODE_FIND: begin
						l_re = (child != '0) && last_lvl;
					end
					MODE_DELETE: begin
						if (child != '0 && last_lvl) begin
							c_we = 1'b1;
							f_we = 1'b1;
						end
					end
					default: begin
						if (child != '0) begin
							l_we = last_lvl;
						end else begin
							f_re = (free_head_q != '0);
						end
					end
				endcase
			end
			ST_CLR: begin
				c_we    = 1'b1;
				c_waddr = {new_q, clr_q};
			end
			ST_LINK: begin
				c_we    = 1'b1;
				c_wdata = new_q;
				l_we    = last_lvl;
				l_addr  = new_q;
			end
			default: begin
			end
		endcase
	end

	fdrt_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT * FANOUT)) u_child (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.re(c_re), .raddr(c_raddr), .rdata(c_rdata)
	);

	fdrt_ram #(.WIDTH(VALUE_BITS), .DEPTH(NODE_COUNT)) u_leaf (
		.clk(clk), .we(l_we), .waddr(l_addr), .wdata(l_wdata),
		.re(l_re), .raddr(l_addr), .rdata(l_rdata)
	);

	fdrt_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_free (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(free_head_q),
		.re(f_re), .raddr(free_head_q), .rdata(f_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_FIND;
			key_q       <= '0;
			value_q     <= '0;
			lvl_q       <= '0;
			node_q      <= '0;
			new_q       <= '0;
			clr_q       <= '0;
			free_head_q <= '0;
			fresh_q     <= (NW+1)'(1);
			root_vld_q  <= '0;
			done        <= 1'b0;
			rsp         <= '0;
		end else begin
			done <= 1'b0;
			if (c_we && c_waddr[CW-1:DIGIT_BITS] == '0) begin
				root_vld_q[c_waddr[DIGIT_BITS-1:0]] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						mode_q  <= req.mode;
						key_q   <= (req.mode == MODE_FIND) ? req.key : (req.key & req.mask);
						value_q <= req.value;
						lvl_q   <= '0;
						node_q  <= '0;
						if (req.mode == MODE_FIND || req.mode == MODE_INSERT ||
							req.mode == MODE_DELETE) begin
							state_q <= ST_RD;
						end else begin
							done <= 1'b1;
							rsp  <= '{status: STATUS_OK, data_out: 32'd0};
						end
					end
				end
				ST_RD: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (child != '0) begin
						if (!last_lvl) begin
							node_q  <= child;
							lvl_q   <= lvl_q + LW'(1);
							key_q   <= key_q >> DIGIT_BITS;
							state_q <= ST_RD;
						end else if (mode_q == MODE_FIND) begin
							state_q <= ST_LEAF;
						end else begin
							if (mode_q == MODE_DELETE) begin
								free_head_q <= child;
							end
							state_q <= ST_IDLE;
							done    <= 1'b1;
							rsp     <= '{status: STATUS_OK, data_out: 32'd0};
						end
					end else if (mode_q == MODE_INSERT) begin
						clr_q <= '0;
						if (free_head_q != '0) begin
							new_q   <= free_head_q;
							state_q <= ST_FLW;
						end else if (fresh_q < (NW+1)'(NODE_COUNT)) begin
							new_q   <= fresh_q[NW-1:0];
							fresh_q <= fresh_q + (NW+1)'(1);
							state_q <= ST_CLR;
						end else begin
							state_q <= ST_IDLE;
							done    <= 1'b1;
							rsp     <= '{status: STATUS_FULL, data_out: 32'd0};
						end
					end else begin
						state_q <= ST_IDLE;
						done    <= 1'b1;
						rsp     <= '{status: STATUS_MISS, data_out: 32'd0};
					end
				end
				ST_FLW: begin
					free_head_q <= f_rdata;
					state_q     <= ST_CLR;
				end
				ST_CLR: begin
					clr_q <= clr_q + DIGIT_BITS'(1);
					if (clr_q == '1) begin
						state_q <= ST_LINK;
					end
				end
				ST_LINK: begin
					if (last_lvl) begin
						state_q <= ST_IDLE;
						done    <= 1'b1;
						rsp     <= '{status: STATUS_OK, data_out: 32'd0};
					end else begin
						node_q  <= new_q;
						lvl_q   <= lvl_q + LW'(1);
						key_q   <= key_q >> DIGIT_BITS;
						state_q <= ST_RD;
					end
				end
				ST_LEAF: begin
					state_q <= ST_IDLE;
					done    <= 1'b1;
					rsp     <= '{status: STATUS_OK, data_out: leaf_ext[31:0]};
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_CLK(a_done_idle, done |-> !busy, "result shown while a transaction still runs")
	`ASSERT_ALWAYS(a_fresh_range, fresh_q <= (NW+1)'(NODE_COUNT), "fresh node count overran")
	`ASSERT_CLK(a_clr_not_root, state_q == ST_CLR |-> new_q != '0, "clearing the root row")
	`ASSERT_CLK(a_lvl_range, busy |-> lvl_q < LW'(HEIGHT), "walk level out of range")

endmodule

// ----- design/fdrt_ram.sv -----
// ---------------------------------------------------------------------------
// fdrt_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module fdrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the fixed-depth radix trie table. A driver sends find,
// insert, delete and unused-mode transactions from a queue. A trie model
// predicts each response, and a monitor compares the responses field by field.
// ---------------------------------------------------------------------------
module tb_top;
	import fdrt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEVELS   = 8;
	localparam int NODES    = 256;
	localparam int WDOG_MAX = 5000;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	fdrt_req_t req = '0;
	logic      done;
	fdrt_rsp_t rsp;

	fixed_depth_radix_trie_table u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	always #1 clk = ~clk;

	fdrt_req_t pending_q[$];
	fdrt_rsp_t answer_q[$];
	int        errors = 0;
	bit        quiet = 0;
	int        wdog = 0;
	int        gap = 0;

	logic [7:0]  trie_slot[NODES][16];
	logic [31:0] trie_leaf[NODES];
	logic [7:0]  trie_link[NODES];
	logic [7:0]  trie_free_head = 0;
	logic [8:0]  trie_fresh = 1;

	function automatic logic [7:0] take_node();
		logic [7:0] n;
		if (trie_free_head != 0) begin
			n = trie_free_head;
			trie_free_head = trie_link[n];
		end else if (trie_fresh < NODES) begin
			n = trie_fresh[7:0];
			trie_fresh++;
		end else begin
			return 8'd0;
		end
		for (int i = 0; i < 16; i++) trie_slot[n][i] = 0;
		return n;
	endfunction

	function automatic fdrt_rsp_t trie_apply(fdrt_req_t t);
		fdrt_rsp_t  r;
		logic [7:0] node;
		logic [7:0] c;
		logic [3:0] d;
		logic [31:0] k;
		r = '0;
		node = 0;
		k = t.key & t.mask;
		case (t.mode)
			MODE_FIND: begin
				for (int l = 0; l < LEVELS; l++) begin
					node = trie_slot[node][t.key[4*l +: 4]];
					if (node == 0) break;
				end
				if (node == 0) r.status = STATUS_MISS;
				else r.data_out = trie_leaf[node];
			end
			MODE_INSERT: begin
				for (int l = 0; l < LEVELS; l++) begin
					d = k[4*l +: 4];
					c = trie_slot[node][d];
					if (c == 0) begin
						c = take_node();
						if (c == 0) begin
							r.status = STATUS_FULL;
							break;
						end
						trie_slot[node][d] = c;
					end
					node = c;
				end
				if (r.status == STATUS_OK) trie_leaf[node] = t.value;
			end
			MODE_DELETE: begin
				for (int l = 0; l < LEVELS; l++) begin
					d = k[4*l +: 4];
					c = trie_slot[node][d];
					if (c == 0) break;
					if (l == LEVELS - 1) begin
						trie_slot[node][d] = 0;
						trie_link[c] = trie_free_head;
						trie_free_head = c;
					end
					node = c;
				end
				if (c == 0) r.status = STATUS_MISS;
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				answer_q.push_back(trie_apply(req));
			end
			if (!start || !busy) begin
				if (gap > 0) begin
					gap--;
					start <= 1'b0;
				end else if (!quiet && $urandom_range(0, 7) == 0) begin
					gap = $urandom_range(1, 4);
					start <= 1'b0;
				end else if (pending_q.size() > 0) begin
					req <= pending_q.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wdog = 0;
		end else begin
			if (done) begin
				if (answer_q.size() == 0) begin
					$display("%0t: unexpected response status=%0d data=%h", $time,
						rsp.status, rsp.data_out);
					errors++;
				end else begin
					fdrt_rsp_t e;
					e = answer_q.pop_front();
					if (rsp.status !== e.status)
						$display("%0t: status expected %0d actual %0d", $time,
							e.status, rsp.status);
					if (rsp.data_out !== e.data_out)
						$display("%0t: data_out expected %h actual %h", $time,
							e.data_out, rsp.data_out);
					if (rsp !== e) errors++;
				end
			end
			if (done || (start && !busy)) wdog = 0;
			else wdog++;
			if (wdog >= WDOG_MAX) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	function automatic fdrt_req_t mk(logic [1:0] m, logic [31:0] k, logic [31:0] mk_mask,
		logic [31:0] v);
		fdrt_req_t t;
		t.mode = m;
		t.key = k;
		t.mask = mk_mask;
		t.value = v;
		return t;
	endfunction

	logic [31:0] key_pool[48];

	initial begin
		fdrt_req_t t;
		int        sel;
		for (int i = 0; i < 16; i++) trie_slot[0][i] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		pending_q.push_back(mk(MODE_FIND, 32'hFFFF_FFFF, 32'h0, 32'h0));
		pending_q.push_back(mk(MODE_DELETE, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0));
		pending_q.push_back(mk(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending_q.push_back(mk(MODE_FIND, 32'hFFFF_FFFF, 32'h0, 32'h0));
		pending_q.push_back(mk(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
		pending_q.push_back(mk(MODE_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending_q.push_back(mk(MODE_INSERT, 32'hDEAD_BEEF, 32'h0, 32'hA5A5_5A5A));
		pending_q.push_back(mk(MODE_FIND, 32'h0, 32'h0, 32'h0));
		pending_q.push_back(mk(MODE_FIND, 32'hDEAD_BEEF, 32'h0, 32'h0));
		pending_q.push_back(mk(MODE_INSERT, 32'hFFFF_FFF0, 32'h0000_FFFF, 32'h1));
		pending_q.push_back(mk(MODE_FIND, 32'h0000_FFF0, 32'h0, 32'h0));
		pending_q.push_back(mk(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending_q.push_back(mk(MODE_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
		pending_q.push_back(mk(MODE_FIND, 32'hFFFF_FFFF, 32'h0, 32'h0));
		pending_q.push_back(mk(MODE_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
		pending_q.push_back(mk(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7));
		pending_q.push_back(mk(MODE_FIND, 32'hFFFF_FFFF, 32'h0, 32'h0));
		pending_q.push_back(mk(MODE_DELETE, 32'h1234_0000, 32'h0, 32'h0));
		pending_q.push_back(mk(MODE_FIND, 32'h0, 32'h0, 32'h0));

		wait (pending_q.size() == 0);
		@(posedge clk);
		wait (!start && answer_q.size() == 0);

		for (int i = 0; i < 48; i++)
			key_pool[i] = {16'($urandom_range(0, 65535)), 12'h0, 4'($urandom_range(0, 3))};
		for (int n = 0; n < 1000; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 3)
				t = mk(MODE_INSERT, $urandom, $urandom, $urandom);
			else if (sel < 6)
				t = mk(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
			else begin
				t = mk(MODE_FIND, key_pool[$urandom_range(0, 47)], 32'hFFFF_FFFF, $urandom);
				sel = $urandom_range(0, 99);
				t.mode = sel < 40 ? MODE_INSERT : sel < 75 ? MODE_FIND : MODE_DELETE;
				if ($urandom_range(0, 9) == 0) t.mask = $urandom;
			end
			while (pending_q.size() > 4) @(posedge clk);
			pending_q.push_back(t);
			if (n == 850) quiet = 1;
		end

		wait (pending_q.size() == 0);
		@(posedge clk);
		wait (!start && answer_q.size() == 0);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+design
design/fdrt_pkg.sv
design/fdrt_ram.sv
design/fixed_depth_radix_trie_table.sv
tb/tb_top.sv
